/* rtl/core/pwc_pkg.sv */
// pwc_pkg: widths and constants shared by the weight combing block
// no dependencies; used by pwc_div and particle_weight_comb
package pwc_pkg;

  // field widths
  localparam int W_W      = 32;  // Q16.16 weight
  localparam int D_W      = 16;  // Q0.16 draw
  localparam int T_W      = 16;  // target / population count
  localparam int IDX_OUT_W = 6;  // particle index port
  localparam int SUM_W    = 38;  // saturating weight sum

  // divider geometry: dividend is {w*t, 16 fraction bits}, divisor is the sum
  localparam int PROD_W   = W_W + T_W;
  localparam int FRAC_W   = D_W;
  localparam int DVD_W    = PROD_W + FRAC_W;
  localparam int DVS_W    = SUM_W;
  localparam int STEP_W   = $clog2(DVD_W);

  localparam logic [T_W-1:0] COUNT_MAX = '1;

endpackage

/* rtl/core/pwc_div.sv */
// pwc_div: restoring radix-2 divider, one quotient bit per cycle
// depends on pwc_pkg for the dividend and divisor widths
module pwc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pwc_pkg::DVD_W-1:0]  dividend,
  input  logic [pwc_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [pwc_pkg::DVD_W-1:0]  quotient,
  output logic [pwc_pkg::DVS_W-1:0]  remainder
);
  import pwc_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;

  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;
  logic [DVS_W-1:0]  rem_nxt;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        dvd_r  <= {dvd_r[DVD_W-2:0], fits};
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

/* rtl/core/particle_weight_comb.sv */
// particle_weight_comb: batch weight combing with roulette on the fraction
// depends on pwc_pkg and the serial divider pwc_div
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in_     | request   | in_valid / in_ready    | weight, uniform_draw, batch_last
//  out_    | result    | out_valid / out_ready  | particle_index, copy_count, new_weight,
//          |           |                        | result_last
//  cfg_    | write     | cfg_wr_en              | cfg_wr_data (target count)
//
// a request without batch_last is stored (dropped when the store is full); the closing
// request starts the mean weight division, then each particle goes through these steps:
// store read, w*t multiply, 64 steps of the shared serial divider, emit.
// a lone particle or a zero sum skips the divider and goes from the multiply step to emit.
// in_ready is low from the closing request until the
// last result is taken; out_valid holds until out_ready. rst_n is synchronous.
module particle_weight_comb #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pwc_pkg::W_W-1:0]       in_weight,
  input  logic [pwc_pkg::D_W-1:0]       in_uniform_draw,
  input  logic                          in_batch_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pwc_pkg::IDX_OUT_W-1:0] out_particle_index,
  output logic [pwc_pkg::T_W-1:0]       out_copy_count,
  output logic [pwc_pkg::W_W-1:0]       out_new_weight,
  output logic                          out_result_last,
  input  logic                          cfg_wr_en,
  input  logic [pwc_pkg::T_W-1:0]       cfg_wr_data
);
  import pwc_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MEAN, S_MEAN_WAIT, S_RD, S_MUL, S_DIV, S_DIV_WAIT, S_EMIT
  } state_t;

  state_t            state_r;
  logic [T_W-1:0]    target_r;
  logic [CNT_W-1:0]  loaded_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  n_r;
  logic [SUM_W-1:0]  s_r;
  logic [T_W-1:0]    t_r;
  logic [W_W-1:0]    mean_r;
  logic [IDX_W-1:0]  j_r;
  logic [W_W-1:0]    rd_w_r;
  logic [D_W-1:0]    rd_d_r;
  logic [PROD_W-1:0] prod_r;
  logic [IDX_OUT_W-1:0] out_index_r;
  logic [T_W-1:0]    out_count_r;
  logic [W_W-1:0]    out_weight_r;
  logic              out_last_r;

  // batch stores
  logic [W_W-1:0]    wmem [CAPACITY];
  logic [D_W-1:0]    dmem [CAPACITY];

  logic              in_acc;
  logic              has_room;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic [CNT_W-1:0]  load_cnt_nxt;
  logic [SUM_W-1:0]  load_sum_nxt;
  logic [T_W-1:0]    t_nxt;

  logic              div_start;
  logic              div_done;
  logic [DVD_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic [DVD_W-1:0]  div_quot;
  logic [DVS_W-1:0]  div_rem;

  logic [PROD_W-1:0] int_q;
  logic [FRAC_W-1:0] frac_q;
  logic              round_up;
  logic [PROD_W:0]   q_inc;
  logic [T_W-1:0]    cnt_sat;
  logic [W_W-1:0]    mean_sat;
  logic              j_last;

  // load path: append to the store, saturating sum
  always_comb begin
    in_acc       = in_valid && in_ready;
    has_room     = (loaded_r < CNT_W'(CAPACITY));
    sum_add      = {1'b0, sum_r} + (SUM_W+1)'(in_weight);
    sum_sat      = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    load_cnt_nxt = has_room ? loaded_r + CNT_W'(1) : loaded_r;
    load_sum_nxt = has_room ? sum_sat : sum_r;
    t_nxt        = (target_r != '0) ? target_r : T_W'(load_cnt_nxt);
  end

  // shared divider operands: mean s/t, then per particle {w*t, frac}/s
  always_comb begin
    div_start    = (state_r == S_MEAN) || (state_r == S_DIV);
    div_dividend = (state_r == S_MEAN) ? DVD_W'(s_r) : {prod_r, {FRAC_W{1'b0}}};
    div_divisor  = (state_r == S_MEAN) ? DVS_W'(t_r) : s_r;
  end

  pwc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // copy count: integer part plus roulette on the fraction
  // draw*s < r*2^16 holds when draw is below the fraction quotient, or equal to
  // it with a nonzero final remainder
  always_comb begin
    int_q    = div_quot[DVD_W-1:FRAC_W];
    frac_q   = div_quot[FRAC_W-1:0];
    round_up = (rd_d_r < frac_q) || ((rd_d_r == frac_q) && (div_rem != '0));
    q_inc    = {1'b0, int_q} + (PROD_W+1)'(round_up);
    cnt_sat  = (q_inc > (PROD_W+1)'(COUNT_MAX)) ? COUNT_MAX : q_inc[T_W-1:0];
    mean_sat = (|div_quot[DVD_W-1:W_W]) ? '1 : div_quot[W_W-1:0];
    j_last   = ((CNT_W'(j_r) + CNT_W'(1)) == n_r);
  end

  // store write on load, registered read in the store read state
  always_ff @(posedge clk) begin
    if (in_acc && has_room) begin
      wmem[loaded_r[IDX_W-1:0]] <= in_weight;
      dmem[loaded_r[IDX_W-1:0]] <= in_uniform_draw;
    end
    if (state_r == S_RD) begin
      rd_w_r <= wmem[j_r];
      rd_d_r <= dmem[j_r];
    end
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      target_r <= '0;
      loaded_r <= '0;
      sum_r    <= '0;
      j_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_batch_last) begin
              loaded_r <= '0;
              sum_r    <= '0;
              n_r      <= load_cnt_nxt;
              s_r      <= load_sum_nxt;
              t_r      <= t_nxt;
              j_r      <= '0;
              if (load_cnt_nxt == '0) begin
                state_r <= S_IDLE;
              end else if ((load_cnt_nxt != CNT_W'(1)) && (load_sum_nxt != '0)) begin
                state_r <= S_MEAN;
              end else begin
                state_r <= S_RD;
              end
            end else begin
              loaded_r <= load_cnt_nxt;
              sum_r    <= load_sum_nxt;
            end
          end
        end
        S_MEAN: begin
          state_r <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_done) begin
            mean_r  <= mean_sat;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          out_index_r <= IDX_OUT_W'(j_r);
          out_last_r  <= j_last;
          if (n_r == CNT_W'(1)) begin
            out_count_r  <= T_W'(1);
            out_weight_r <= rd_w_r;
            state_r      <= S_EMIT;
          end else if (s_r == '0) begin
            out_count_r  <= '0;
            out_weight_r <= '0;
            state_r      <= S_EMIT;
          end else begin
            prod_r  <= PROD_W'(rd_w_r) * PROD_W'(t_r);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            out_count_r  <= cnt_sat;
            out_weight_r <= mean_r;
            state_r      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              j_r     <= j_r + IDX_W'(1);
              state_r <= S_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = (state_r == S_EMIT);
  assign out_particle_index = out_index_r;
  assign out_copy_count     = out_count_r;
  assign out_new_weight     = out_weight_r;
  assign out_result_last    = out_last_r;

endmodule

/* test/particle_weight_comb_tb.sv */
// particle_weight_comb_tb: self-checking bench for the particle weight combing block
// drives weight requests and the target register, predicts every per-particle result
// depends on pwc_pkg and particle_weight_comb
`timescale 1ns / 1ps

module particle_weight_comb_tb;
  import pwc_pkg::*;

  localparam int CAP = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

  typedef struct {
    logic [IDX_OUT_W-1:0] index;
    logic [T_W-1:0]       count;
    logic [W_W-1:0]       weight;
    logic                 last;
  } particle_result_t;

  // batch store, running sum and the expected per-particle results
  class comb_scoreboard;
    logic [W_W-1:0]   weight_mem [CAP];
    logic [D_W-1:0]   draw_mem [CAP];
    logic [63:0]      batch_sum;
    int unsigned      batch_len;
    logic [T_W-1:0]   target;
    particle_result_t combed_q [$];
    int unsigned      errors;
    int unsigned      checked;

    function new();
      batch_sum = '0;
      batch_len = 0;
      target = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_target(input logic [T_W-1:0] v);
      target = v;
    endfunction

    function int unsigned pending();
      return combed_q.size();
    endfunction

    function void note_request(input logic [W_W-1:0] w, input logic [D_W-1:0] d,
                               input logic closes);
      int unsigned      n;
      int unsigned      j;
      logic [63:0]      s;
      logic [63:0]      t;
      logic [63:0]      mean;
      logic [63:0]      num;
      logic [63:0]      q;
      logic [63:0]      r;
      particle_result_t res;
      // a full store drops the request, batch_last still closes the batch
      if (batch_len < CAP) begin
        weight_mem[batch_len] = w;
        draw_mem[batch_len] = d;
        batch_len++;
        batch_sum = batch_sum + {32'b0, w};
        if (batch_sum > SUM_LIMIT) batch_sum = SUM_LIMIT;
      end
      if (!closes) return;
      n = batch_len;
      s = batch_sum;
      batch_len = 0;
      batch_sum = '0;
      if (n == 0) return;
      // lone particle passes through untouched
      if (n == 1) begin
        res.index = '0;
        res.count = T_W'(1);
        res.weight = weight_mem[0];
        res.last = 1'b1;
        combed_q.push_back(res);
        return;
      end
      t = (target != 0) ? {48'b0, target} : 64'(n);
      mean = (s != 0) ? s / t : 64'd0;
      if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
      for (j = 0; j < n; j++) begin
        res.index = IDX_OUT_W'(j);
        res.last = (j + 1 == n);
        res.count = '0;
        res.weight = '0;
        // exact ratio w*t/s, roulette on the remainder against the draw
        if (s != 0) begin
          num = {32'b0, weight_mem[j]} * t;
          q = num / s;
          r = num % s;
          if ({48'b0, draw_mem[j]} * s < (r << 16)) q++;
          res.count = (q > {48'b0, COUNT_MAX}) ? COUNT_MAX : q[T_W-1:0];
          res.weight = mean[W_W-1:0];
        end
        combed_q.push_back(res);
      end
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 50) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task check_result(input logic [IDX_OUT_W-1:0] idx, input logic [T_W-1:0] cnt,
                      input logic [W_W-1:0] wt, input logic lst);
      particle_result_t exp_r;
      checked++;
      if (combed_q.size() == 0) begin
        report($sformatf("unexpected result idx %0d count %0d weight %h last %0b",
                         idx, cnt, wt, lst));
        return;
      end
      exp_r = combed_q.pop_front();
      if (idx !== exp_r.index || cnt !== exp_r.count || wt !== exp_r.weight ||
          lst !== exp_r.last)
        report($sformatf("got idx %0d count %0d weight %h last %0b, want %0d %0d %h %0b",
                         idx, cnt, wt, lst, exp_r.index, exp_r.count, exp_r.weight,
                         exp_r.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [W_W-1:0]       in_weight;
  logic [D_W-1:0]       in_uniform_draw;
  logic                 in_batch_last;
  logic                 out_valid;
  logic                 out_ready;
  logic [IDX_OUT_W-1:0] out_particle_index;
  logic [T_W-1:0]       out_copy_count;
  logic [W_W-1:0]       out_new_weight;
  logic                 out_result_last;
  logic                 cfg_wr_en;
  logic [T_W-1:0]       cfg_wr_data;

  comb_scoreboard sb = new();
  bit             idle_on;
  bit             hold_req;
  int unsigned    cycle_count;
  int unsigned    requests;
  int unsigned    batches;
  int unsigned    settings;

  particle_weight_comb #(.CAPACITY(CAP)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_weight          (in_weight),
    .in_uniform_draw    (in_uniform_draw),
    .in_batch_last      (in_batch_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_particle_index (out_particle_index),
    .out_copy_count     (out_copy_count),
    .out_new_weight     (out_new_weight),
    .out_result_last    (out_result_last),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped at the cycle limit with %0d results outstanding", sb.pending());
    $display("FAILED: results differ");
    $finish;
  end

  // result side: random ready gaps, one long hold-off on request
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      sb.check_result(out_particle_index, out_copy_count, out_new_weight, out_result_last);
      @(negedge clk);
    end
  end

  // offer one request, keep valid high until taken
  task automatic send_request(input logic [W_W-1:0] w, input logic [D_W-1:0] d,
                              input logic closes);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_weight = w;
    in_uniform_draw = d;
    in_batch_last = closes;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(w, d, closes);
    requests++;
    if (closes) batches++;
    @(negedge clk);
  endtask

  // batch of random weights, mixing zeros, full scale, small and wide values
  task automatic send_batch(input int unsigned size, input bit all_zero);
    int unsigned    i;
    logic [W_W-1:0] w;
    for (i = 0; i < size; i++) begin
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = '1;
        2, 3, 4: w = W_W'($urandom_range(0, 32'h0003_FFFF));
        default: w = $urandom;
      endcase
      if (all_zero) w = '0;
      send_request(w, D_W'($urandom_range(0, 65535)), i == size - 1);
    end
  endtask

  // target writes only while the block is idle
  task automatic write_target(input logic [T_W-1:0] v);
    cfg_wr_data = v;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_target(v);
    settings++;
  endtask

  task automatic drain_and_settle();
    in_valid = 1'b0;
    in_batch_last = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // stimulus
  initial begin
    int unsigned    p;
    int unsigned    left;
    int unsigned    size;
    logic [T_W-1:0] tgt;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_weight = '0;
    in_uniform_draw = '0;
    in_batch_last = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    requests = 0;
    batches = 0;
    settings = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (4) @(negedge clk);

    // target zero: lone particle, zero sum, extremes, two full-scale weights
    write_target('0);
    send_request(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_request(32'h0000_0000, 16'h0000, 1'b0);
    send_request(32'h0000_0000, 16'hFFFF, 1'b0);
    send_request(32'h0000_0000, 16'h1234, 1'b1);
    send_request(32'h0001_0000, 16'h0000, 1'b0);
    send_request(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_request(32'h0000_0001, 16'h8000, 1'b1);
    send_request(32'hFFFF_FFFF, 16'h0000, 1'b0);
    send_request(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    drain_and_settle();

    // target one: mean weight overflows 32 bits and saturates
    write_target(16'd1);
    send_request(32'hFFFF_FFFF, 16'h0000, 1'b0);
    send_request(32'hFFFF_FFFF, 16'h7FFF, 1'b1);
    send_request(32'h0003_0000, 16'h4000, 1'b0);
    send_request(32'h0001_0000, 16'hC000, 1'b1);
    drain_and_settle();

    // largest target
    write_target(COUNT_MAX);
    send_request(32'h0000_0001, 16'h0000, 1'b0);
    send_request(32'h8000_0000, 16'hFFFF, 1'b0);
    send_request(32'h0000_FFFF, 16'h0001, 1'b0);
    send_request(32'h1234_5678, 16'h8000, 1'b1);
    drain_and_settle();

    // small target, lone particle ignores it
    write_target(16'd3);
    send_request(32'h0002_0000, 16'hAAAA, 1'b0);
    send_request(32'h0001_0000, 16'h5555, 1'b0);
    send_request(32'h0001_0000, 16'h2000, 1'b0);
    send_request(32'h0003_0000, 16'hFFFF, 1'b1);
    send_request(32'h0005_0000, 16'h0000, 1'b1);
    drain_and_settle();

    // random phases, one per target setting
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       tgt = T_W'($urandom_range(1, 65535));
        1:       tgt = '0;
        2:       tgt = 16'd2;
        3:       tgt = COUNT_MAX;
        4:       tgt = T_W'($urandom_range(1, 8));
        default: tgt = '0;
      endcase
      idle_on = (p != 2);
      write_target(tgt);
      // overfull batch with the result side held off, so the input backs up
      if (p == 1) begin
        hold_req = 1'b1;
        send_batch($urandom_range(CAP + 1, CAP + 6), 1'b0);
      end
      left = 22;
      while (left > 0) begin
        size = $urandom_range(1, 10);
        if (size > left) size = left;
        send_batch(size, $urandom_range(0, 9) == 0);
        left -= size;
      end
      drain_and_settle();
    end

    $display("covered %0d requests in %0d batches over %0d target settings",
             requests, batches, settings);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/pwc_pkg.sv
rtl/core/pwc_div.sv
rtl/core/particle_weight_comb.sv
test/particle_weight_comb_tb.sv
